>>> hw/rtl/dq_pkg.sv
package dq_pkg;

    localparam int DATA_W      = 32;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_DFLT  = 16;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_word;

endpackage

>>> hw/rtl/double_ended_queue.sv
// Each result passes the stage-1 register and then the output register.
// Throughput: one item per cycle unless the output stalls; the ring store has
// one write, one registered read port; pointer and count update in the accept cycle.
// Reset (synchronous, active low) empties the queue and clears head, count and
// both stage valid flags; store contents stay undefined until written.
module double_ended_queue #(
    parameter  int DEPTH      = dq_pkg::DEPTH_DFLT,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int OUT_DATA_W = ((dq_pkg::DATA_W + CNT_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [dq_pkg::DATA_W-1:0]     i_s_tdata,   // [31:0] value
    input  logic [dq_pkg::MODE_W-1:0]     i_s_tuser,   // [2:0] mode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [OUT_DATA_W-1:0]         o_m_tdata,   // [31:0] data, then occupancy
    output logic [dq_pkg::STATUS_W-1:0]   o_m_tuser    // [1:0] status
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SUM_W = CNT_W + 1;
    localparam int PAD_W = OUT_DATA_W - DATA_W - CNT_W;

    logic [PTR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_s1_valid;
    logic                r_s1_rd;
    logic [STATUS_W-1:0] r_s1_status;
    logic [CNT_W-1:0]    r_s1_count;
    logic                r_out_valid;
    t_word               r_out_data;
    logic [STATUS_W-1:0] r_out_status;
    logic [CNT_W-1:0]    r_out_count;

    logic                s_acc, s1_adv, out_free;
    logic                empty, full;
    logic [SUM_W-1:0]    sum_next, sum_cur;
    logic [PTR_W-1:0]    rear_next, rear_cur, head_dec, head_inc;
    logic                wr_en, rd_en;
    logic [PTR_W-1:0]    wr_addr, rd_addr;
    logic [STATUS_W-1:0] n_status;
    t_word               rd_data;
    logic [MODE_W-1:0]   mode;

    assign mode     = i_s_tuser;
    assign out_free = !r_out_valid || i_m_tready;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s_acc    = i_s_tvalid && o_s_tready;

    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(DEPTH));

    assign sum_next = SUM_W'(r_head) + SUM_W'(r_count);
    assign sum_cur  = sum_next - SUM_W'(1);
    assign rear_next = (sum_next >= SUM_W'(DEPTH)) ? PTR_W'(sum_next - SUM_W'(DEPTH))
                                                   : PTR_W'(sum_next);
    assign rear_cur  = (sum_cur >= SUM_W'(DEPTH)) ? PTR_W'(sum_cur - SUM_W'(DEPTH))
                                                  : PTR_W'(sum_cur);
    assign head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);
    assign head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = rear_next;
        rd_addr  = r_head;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = head_dec;
                    n_count = r_count + CNT_W'(1);
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                end
            end
            MODE_PUSH_REAR: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    wr_en   = 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - CNT_W'(1);
                    rd_en   = 1'b1;
                end
            end
            MODE_POP_REAR: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = rear_cur;
                end
            end
            MODE_PEEK_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            MODE_PEEK_REAR: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rear_cur;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    dq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s_acc && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (t_word'(i_s_tdata)),
        .i_rd_en   (s_acc && rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (o_s_tready) begin
                r_s1_valid <= s_acc;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_rd     <= rd_en;
            r_s1_status <= n_status;
            r_s1_count  <= n_count;
        end
        if (s1_adv) begin
            r_out_data   <= r_s1_rd ? rd_data : '0;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    generate
        if (PAD_W > 0) begin : g_pad
            assign o_m_tdata = {{PAD_W{1'b0}}, r_out_count, r_out_data};
        end else begin : g_nopad
            assign o_m_tdata = {r_out_count, r_out_data};
        end
    endgenerate

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= PTR_W'(DEPTH - 1))
        else $error("head outside ring");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FULL || r_out_status == ST_EMPTY))
        |-> (r_out_data == '0))
        else $error("failed item carries nonzero data");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_REAR))
        |=> $stable(r_count) && $stable(r_head))
        else $error("insert into full queue changed state");

    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_s1_valid && r_s1_count == r_count))
        else $error("stage occupancy differs from count");
`endif

endmodule

>>> hw/rtl/dq_store.sv
module dq_store #(
    parameter int  DEPTH  = dq_pkg::DEPTH_DFLT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  dq_pkg::t_word         i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output dq_pkg::t_word         o_rd_data
);
    import dq_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
